// ===== hw/rtl/nnt_pkg.sv =====
// Package for the nearest neighbor table: sizes, field layout, opcodes and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package nnt_pkg;

    // Storage and search sizing.
    localparam int MAX_POINTS = 1024;
    localparam int NEIGHBORS  = 6;
    localparam int COORD_W    = 16;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int FILL_W = $clog2(NEIGHBORS + 1);
    localparam int POS_W  = 3 * COORD_W;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * COORD_W;
    localparam int DIST_W = SQ_W + 2;

    // Fixed field widths of the stream items.
    localparam int IDX_W      = 10;
    localparam int FIELD_W    = 16;
    localparam int CNT_W      = 11;
    localparam int OUT_SLOTS  = 6;
    localparam int OUT_CNT_W  = 3;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 64;

    // Input tdata layout.
    localparam int IN_IDX_LSB = 0;
    localparam int IN_X_LSB   = IN_IDX_LSB + IDX_W;
    localparam int IN_Y_LSB   = IN_X_LSB + FIELD_W;
    localparam int IN_Z_LSB   = IN_Y_LSB + FIELD_W;

    // Output tdata layout.
    localparam int OUT_CNT_LSB = OUT_SLOTS * IDX_W;

    // Item kinds carried in tuser.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic load_wr;   // write the accepted load item into the store
        logic clear;     // start of a query: reset slots and scan counter
        logic cap_q;     // capture the query position from the read port
        logic issue;     // read the next scanned point
        logic push;      // load the result into the output register
    } t_cmd;

    typedef struct packed {
        logic in_range;   // query index is below the effective point count
        logic scan_last;  // the current scan address is the last point
        logic pipe_empty; // no distance is in flight
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/nearest_neighbor_table_core.sv =====
// Nearest neighbor table, top level: wires the sequencer to the datapath.
// Depends on nnt_pkg, nnt_ctrl, nnt_dpath (which holds the nnt_ram store).
//
// The block keeps up to 1024 point positions (x, y, z in Q1.14) in a single
// RAM and answers six-nearest-neighbor queries by brute force. A load item
// (tuser = 0) writes one position into the store. A query item
// (tuser = 1) names a point; the block reads every other point below the
// configured point count in index order, one RAM read per cycle, computes the
// exact squared distance in a four-stage pipeline, and keeps six slots. The
// first six points fill the slots; later points replace the first slot holding
// the largest distance, and only when strictly closer, so ties keep the lower
// index. The scan is bound by the single read port of the position
// store; after it the pipeline drains, and the result is pushed once the
// output register is free. A query whose index is not below the
// point count returns count zero right away. The result reports the slot
// order, not sorted by distance, with unused slots as zero. Positions are not
// cleared at reset: a point inside the count must be loaded before it is
// searched. The user writes the point count over its own channel only while
// the block is idle, which the block does not enforce; values above 1024 act
// as 1024. Input items are accepted only between queries, but loads and new
// queries are taken while a finished result waits in the output register.
`default_nettype none

module nearest_neighbor_table_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration: point_count.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [nnt_pkg::CNT_W-1:0]         i_cfg_data,
    // Input items.
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: point_index[9:0], pos_x[25:10], pos_y[41:26], pos_z[57:42], zero pad
    input  wire logic [nnt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: mode (0 load, 1 query)
    input  wire logic                              s_axis_tuser,
    // Result items.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: neighbor_a[9:0], neighbor_b[19:10], neighbor_c[29:20],
    // neighbor_d[39:30], neighbor_e[49:40], neighbor_f[59:50],
    // neighbor_count[62:60], zero pad
    output logic      [nnt_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    import nnt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // The point count register has no reason to stall a write.
    assign o_cfg_ready = 1'b1;

    nnt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    nnt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/nnt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module nnt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nnt_ctrl.sv =====
// Sequencer of the nearest neighbor table: input handshake and query steps.
// Depends on nnt_pkg for the command and status structs.
`default_nettype none

module nnt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_mode,
    output logic                o_in_ready,
    input  wire nnt_pkg::t_sts  i_sts,
    output nnt_pkg::t_cmd       o_cmd
);

    import nnt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_QPOS  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode == MODE_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_state     = i_sts.in_range ? ST_QPOS : ST_DONE;
                    end
                end
            end
            ST_QPOS: begin
                o_cmd.cap_q = 1'b1;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nnt_dpath.sv =====
// Datapath of the nearest neighbor table: point count register, position
// store, distance pipeline, neighbor slots and output register.
// Depends on nnt_pkg and nnt_ram.
`default_nettype none

module nnt_dpath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [nnt_pkg::CNT_W-1:0]         i_cfg_data,
    input  wire logic [nnt_pkg::IN_DATA_W-1:0]     i_in_data,
    input  wire nnt_pkg::t_cmd                     i_cmd,
    output nnt_pkg::t_sts                          o_sts,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [nnt_pkg::OUT_DATA_W-1:0]    o_out_data
);

    import nnt_pkg::*;

    // Configuration and effective point count.
    logic [CNT_W-1:0] r_pc;
    logic [CNT_W-1:0] w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else if (i_cfg_valid) begin
            r_pc <= i_cfg_data;
        end
    end

    assign w_n = (r_pc > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : r_pc;

    // Input fields.
    logic [IDX_W-1:0]   w_in_idx;
    logic [COORD_W-1:0] w_in_x, w_in_y, w_in_z;

    assign w_in_idx = i_in_data[IN_IDX_LSB +: IDX_W];
    assign w_in_x   = i_in_data[IN_X_LSB +: COORD_W];
    assign w_in_y   = i_in_data[IN_Y_LSB +: COORD_W];
    assign w_in_z   = i_in_data[IN_Z_LSB +: COORD_W];

    // Position store.
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [POS_W-1:0]  w_rd_data;
    logic [ADDR_W-1:0] r_j, r_qidx;

    assign w_wr_en   = i_cmd.load_wr && (CNT_W'(w_in_idx) < CNT_W'(MAX_POINTS));
    assign w_rd_addr = i_cmd.issue ? r_j : ADDR_W'(w_in_idx);

    nnt_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (ADDR_W'(w_in_idx)),
        .i_wr_data ({w_in_z, w_in_y, w_in_x}),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Scan counter and query position.
    logic [COORD_W-1:0] r_qx, r_qy, r_qz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_j    <= '0;
            r_qidx <= ADDR_W'(w_in_idx);
        end else if (i_cmd.issue) begin
            r_j <= r_j + ADDR_W'(1);
        end
        if (i_cmd.cap_q) begin
            r_qx <= w_rd_data[0 +: COORD_W];
            r_qy <= w_rd_data[COORD_W +: COORD_W];
            r_qz <= w_rd_data[2*COORD_W +: COORD_W];
        end
    end

    // Distance pipeline: read, differences, squares, sum. The queried point
    // itself never enters the pipeline.
    logic                     r_va, r_vb, r_vc, r_vd;
    logic [ADDR_W-1:0]        r_ja, r_jb, r_jc, r_jd;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]          r_sqx, r_sqy, r_sqz;
    logic [DIST_W-1:0]        r_d;

    logic signed [DIFF_W-1:0]   w_dx, w_dy, w_dz;
    logic signed [2*DIFF_W-1:0] w_px, w_py, w_pz;

    assign w_dx = $signed({w_rd_data[COORD_W-1], w_rd_data[0 +: COORD_W]})
                - $signed({r_qx[COORD_W-1], r_qx});
    assign w_dy = $signed({w_rd_data[2*COORD_W-1], w_rd_data[COORD_W +: COORD_W]})
                - $signed({r_qy[COORD_W-1], r_qy});
    assign w_dz = $signed({w_rd_data[3*COORD_W-1], w_rd_data[2*COORD_W +: COORD_W]})
                - $signed({r_qz[COORD_W-1], r_qz});
    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_pz = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_cmd.issue && (r_j != r_qidx);
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ja  <= r_j;
        r_jb  <= r_ja;
        r_jc  <= r_jb;
        r_jd  <= r_jc;
        r_dx  <= w_dx;
        r_dy  <= w_dy;
        r_dz  <= w_dz;
        r_sqx <= w_px[SQ_W-1:0];
        r_sqy <= w_py[SQ_W-1:0];
        r_sqz <= w_pz[SQ_W-1:0];
        r_d   <= DIST_W'(r_sqx) + DIST_W'(r_sqy) + DIST_W'(r_sqz);
    end

    // Neighbor slots. The worst slot is the lowest-numbered one holding the
    // largest distance; all pairwise compares run side by side.
    logic [ADDR_W-1:0] r_slot_idx  [NEIGHBORS];
    logic [DIST_W-1:0] r_slot_dist [NEIGHBORS];
    logic [FILL_W-1:0] r_filled;
    logic [NEIGHBORS-1:0] w_worst, w_farther;
    logic                 w_full;

    always_comb begin
        for (int s = 0; s < NEIGHBORS; s++) begin
            w_worst[s]   = 1'b1;
            w_farther[s] = r_slot_dist[s] > r_d;
            for (int t = 0; t < NEIGHBORS; t++) begin
                if (t < s) begin
                    w_worst[s] = w_worst[s] && (r_slot_dist[s] > r_slot_dist[t]);
                end else if (t > s) begin
                    w_worst[s] = w_worst[s] && (r_slot_dist[s] >= r_slot_dist[t]);
                end
            end
        end
    end

    assign w_full = (r_filled == FILL_W'(NEIGHBORS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_filled <= '0;
            for (int s = 0; s < NEIGHBORS; s++) begin
                r_slot_idx[s] <= '0;
            end
        end else if (r_vd) begin
            if (!w_full) begin
                r_filled <= r_filled + FILL_W'(1);
            end
            for (int s = 0; s < NEIGHBORS; s++) begin
                if ((!w_full && r_filled == FILL_W'(s)) ||
                    (w_full && w_worst[s] && (|w_farther))) begin
                    r_slot_idx[s]  <= r_jd;
                    r_slot_dist[s] <= r_d;
                end
            end
        end
    end

    // Result assembly and output register.
    logic [OUT_DATA_W-1:0] w_result;
    logic [OUT_CNT_W-1:0]  w_cnt;

    assign w_cnt = ((FILL_W + 3)'(r_filled) > (FILL_W + 3)'(7)) ? OUT_CNT_W'(7)
                 : OUT_CNT_W'(r_filled);

    always_comb begin
        w_result = '0;
        for (int k = 0; k < OUT_SLOTS; k++) begin
            if (k < NEIGHBORS) begin
                w_result[k*IDX_W +: IDX_W] = IDX_W'(r_slot_idx[k]);
            end
        end
        w_result[OUT_CNT_LSB +: OUT_CNT_W] = w_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
        if (i_cmd.push) begin
            o_out_data <= w_result;
        end
    end

    // Status to the sequencer.
    assign o_sts.in_range   = CNT_W'(w_in_idx) < w_n;
    assign o_sts.scan_last  = (CNT_W'(r_j) == (w_n - CNT_W'(1)));
    assign o_sts.pipe_empty = !(r_va || r_vb || r_vc || r_vd);
    assign o_sts.out_free   = !o_out_valid || i_out_ready;

endmodule

`default_nettype wire
